// File: sv/bfa_pkg.sv
// Package for the bitmap first-free allocator.
// Holds sizes, command and register codes shared by the interfaces and the RTL.
// No dependencies.
package bfa_pkg;

	localparam int BITMAP_BYTES = 512;
	localparam int ADDR_W       = $clog2(BITMAP_BYTES);
	localparam int POS_W        = (ADDR_W + 1 > 10) ? ADDR_W + 1 : 10;
	localparam int BLOCK_W      = 12;
	localparam int NUM_W        = ((ADDR_W + 3 > BLOCK_W) ? ADDR_W + 3 : BLOCK_W) + 1;
	localparam int NUMBER_MAX   = 4095;
	localparam logic [7:0] FULL_BYTE = 8'hFF;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 12;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_INODE = 2'd1,
		CMD_DATA  = 2'd2
	} cmd_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INODE_FIRST_BYTE = 3'd0,
		REG_DATA_FIRST_BYTE  = 3'd1,
		REG_DATA_END_BYTE    = 3'd2,
		REG_DATA_FIRST_BLOCK = 3'd3,
		REG_LAST_BLOCK       = 3'd4
	} reg_index_t;

endpackage

// File: sv/bfa_ifs.sv
// Channel interfaces for the bitmap first-free allocator: command, response, config.
// Depends on bfa_pkg.
interface bfa_cmd_if;
	import bfa_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [8:0] byte_index;
	logic [7:0] byte_value;
	modport source(output valid, command, byte_index, byte_value, input ready);
	modport sink(input valid, command, byte_index, byte_value, output ready);
endinterface

interface bfa_rsp_if;
	import bfa_pkg::*;
	logic               valid;
	logic               ready;
	logic               status;
	logic [BLOCK_W-1:0] block_number;
	modport source(output valid, status, block_number, input ready);
	modport sink(input valid, status, block_number, output ready);
endinterface

interface bfa_cfg_if;
	import bfa_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: sv/bfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/bitmap_first_free_allocator.sv
// Bitmap first-free allocator: a load, an unknown command or an empty range goes from
// accept through S_DONE to the registered response beat; a scan goes through S_SCAN and, on a
// hit, S_CALC and S_COMMIT to S_DONE; one bitmap RAM read per cycle. One item at a time.
// After reset a clearing pass writes zero to all BITMAP_BYTES bytes, with no command beat
// taken meanwhile; config beats are taken at all times.
// Depends on bfa_pkg, bfa_ifs, bfa_ram.
module bitmap_first_free_allocator (
	input  logic clk,
	input  logic arst_n,
	bfa_cmd_if.sink   cmd,
	bfa_rsp_if.source rsp,
	bfa_cfg_if.sink   cfg
);
	import bfa_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_CALC,
		S_COMMIT,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [POS_W-1:0]   pos_q;
	logic [POS_W-1:0]   stop_q;
	logic [POS_W-1:0]   pos_s1;
	logic               rd_valid_s1;
	logic [1:0]         op_q;
	logic [ADDR_W-1:0]  hit_addr_q;
	logic [2:0]         bit_q;
	logic [7:0]         byte_q;
	logic [NUM_W-1:0]   num_q;
	logic               res_status_q;
	logic [BLOCK_W-1:0] res_num_q;
	logic               rsp_valid_q;
	logic               rsp_status_q;
	logic [BLOCK_W-1:0] rsp_num_q;

	logic [8:0]  inode_first_q;
	logic [8:0]  data_first_q;
	logic [9:0]  data_end_q;
	logic [11:0] data_first_block_q;
	logic [11:0] last_block_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic [7:0]        ram_rdata;

	logic             cmd_fire;
	logic [POS_W-1:0] scan_start;
	logic [POS_W-1:0] scan_end;
	logic [POS_W-1:0] scan_stop;
	logic             load_ok;
	logic [2:0]       zero_bit;
	logic             hit;
	logic [POS_W-1:0] offset;
	logic             num_ok;
	logic             rsp_load;

	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.block_number = rsp_num_q;

	assign load_ok = POS_W'(cmd.byte_index) < POS_W'(BITMAP_BYTES);

	always_comb begin
		if (cmd.command == CMD_INODE) begin
			scan_start = POS_W'(inode_first_q);
			scan_end   = POS_W'(data_first_q);
		end else begin
			scan_start = POS_W'(data_first_q);
			scan_end   = POS_W'(data_end_q);
		end
		scan_stop = (scan_end > POS_W'(BITMAP_BYTES)) ? POS_W'(BITMAP_BYTES) : scan_end;
	end

	always_comb begin
		zero_bit = '0;
		for (int i = 7; i >= 0; i--) begin
			if (!ram_rdata[i]) begin
				zero_bit = 3'(i);
			end
		end
	end

	assign hit    = rd_valid_s1 && (ram_rdata != FULL_BYTE);
	assign offset = POS_W'(hit_addr_q) - POS_W'(data_first_q);
	assign num_ok = (op_q == CMD_INODE) ? (num_q <= NUM_W'(NUMBER_MAX))
	                                    : (num_q <= NUM_W'(last_block_q));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = hit_addr_q;
		ram_wdata = byte_q | (8'd1 << bit_q);
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[ADDR_W-1:0];
				ram_wdata = '0;
			end
			S_IDLE: begin
				ram_we    = cmd_fire && (cmd.command == CMD_LOAD) && load_ok;
				ram_waddr = ADDR_W'(cmd.byte_index);
				ram_wdata = cmd.byte_value;
			end
			S_COMMIT: begin
				ram_we = num_ok;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	bfa_ram #(
		.WIDTH(8),
		.DEPTH(BITMAP_BYTES)
	) u_bitmap (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(pos_q[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inode_first_q      <= 9'd0;
			data_first_q       <= 9'd256;
			data_end_q         <= 10'd512;
			data_first_block_q <= 12'd0;
			last_block_q       <= 12'd2047;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_INODE_FIRST_BYTE: inode_first_q      <= cfg.data[8:0];
				REG_DATA_FIRST_BYTE:  data_first_q       <= cfg.data[8:0];
				REG_DATA_END_BYTE:    data_end_q         <= cfg.data[9:0];
				REG_DATA_FIRST_BLOCK: data_first_block_q <= cfg.data;
				REG_LAST_BLOCK:       last_block_q       <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			pos_q        <= '0;
			stop_q       <= '0;
			pos_s1       <= '0;
			rd_valid_s1  <= 1'b0;
			op_q         <= '0;
			hit_addr_q   <= '0;
			bit_q        <= '0;
			byte_q       <= '0;
			num_q        <= '0;
			res_status_q <= 1'b0;
			res_num_q    <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= 1'b0;
			rsp_num_q    <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			rd_valid_s1 <= (state_q == S_SCAN) && (pos_q < stop_q);
			pos_s1      <= pos_q;
			unique case (state_q)
				S_CLEAR: begin
					if (pos_q == POS_W'(BITMAP_BYTES - 1)) begin
						state_q <= S_IDLE;
					end
					pos_q <= pos_q + 1'b1;
				end
				S_IDLE: begin
					if (cmd_fire) begin
						op_q      <= cmd.command;
						res_num_q <= '0;
						pos_q     <= scan_start;
						stop_q    <= scan_stop;
						unique case (cmd.command)
							CMD_LOAD: begin
								res_status_q <= 1'b0;
								state_q      <= S_DONE;
							end
							CMD_INODE, CMD_DATA: begin
								res_status_q <= 1'b1;
								state_q <= (scan_start < scan_stop) ? S_SCAN : S_DONE;
							end
							default: begin
								res_status_q <= 1'b1;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					pos_q <= pos_q + 1'b1;
					if (hit) begin
						hit_addr_q <= pos_s1[ADDR_W-1:0];
						bit_q      <= zero_bit;
						byte_q     <= ram_rdata;
						state_q    <= S_CALC;
					end else if ((pos_q >= stop_q) && !rd_valid_s1) begin
						state_q <= S_DONE;
					end
				end
				S_CALC: begin
					if (op_q == CMD_INODE) begin
						num_q <= NUM_W'({hit_addr_q, bit_q});
					end else begin
						num_q <= NUM_W'(data_first_block_q)
						       + NUM_W'({offset[ADDR_W-1:0], bit_q});
					end
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (num_ok) begin
						res_status_q <= 1'b0;
						res_num_q    <= num_q[BLOCK_W-1:0];
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						rsp_status_q <= res_status_q;
						rsp_num_q    <= res_num_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status |-> rsp.block_number == '0)
		else $error("failed response carries a nonzero block number");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("command taken while an item is in work");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN || state_q == S_CALC || state_q == S_DONE |-> !ram_we)
		else $error("bitmap written outside load, clear or commit");

	a_data_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) && op_q == CMD_DATA && !rsp_status_q
		|-> rsp_num_q <= last_block_q)
		else $error("data block above last block returned");

	a_clear_blocks_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !rsp_valid_q && ram_we && !cmd.ready)
		else $error("response, command or idle RAM port during clearing pass");

endmodule

// File: test/bitmap_first_free_allocator_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the bitmap first-free allocator: tracks config beats, keeps its own
// bitmap, predicts one response per command beat and compares response beats in order.
// Depends on bfa_pkg and bfa_ifs.
module bitmap_first_free_allocator_checker (
	input  logic clk,
	input  logic arst_n,
	bfa_cmd_if   cmd,
	bfa_rsp_if   rsp,
	bfa_cfg_if   cfg,
	output int   failures,
	output int   pending
);
	import bfa_pkg::*;

	localparam logic [8:0]  INODE_FIRST_RESET = 9'd0;
	localparam logic [8:0]  DATA_FIRST_RESET  = 9'd256;
	localparam logic [9:0]  DATA_END_RESET    = 10'd512;
	localparam logic [11:0] BASE_BLOCK_RESET  = 12'd0;
	localparam logic [11:0] LAST_BLOCK_RESET  = 12'd2047;

	typedef struct packed {
		logic               status;
		logic [BLOCK_W-1:0] block_number;
	} grant_t;

	logic [7:0]  usage_map [BITMAP_BYTES];
	logic [8:0]  inode_start;
	logic [8:0]  data_begin;
	logic [9:0]  data_stop;
	logic [11:0] data_base;
	logic [11:0] block_limit;
	grant_t      grants_due [$];

	task automatic report_mismatch(input string what);
		failures++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	function automatic logic find_free(input int first, input int stop,
		output int byte_at, output int bit_at);
		int last;
		last = (stop > BITMAP_BYTES) ? BITMAP_BYTES : stop;
		byte_at = 0;
		bit_at = 0;
		for (int p = first; p < last; p++)
			if (usage_map[p] != FULL_BYTE)
				for (int b = 0; b < 8; b++)
					if (!usage_map[p][b]) begin
						byte_at = p;
						bit_at = b;
						return 1'b1;
					end
		return 1'b0;
	endfunction

	function automatic grant_t apply_command(input logic [1:0] op, input logic [8:0] idx,
		input logic [7:0] val);
		grant_t g;
		int     byte_at;
		int     bit_at;
		int     number;
		g.status = 1'b1;
		g.block_number = '0;
		case (op)
			CMD_LOAD: begin
				if (idx < BITMAP_BYTES)
					usage_map[idx] = val;
				g.status = 1'b0;
			end
			CMD_INODE: begin
				if (find_free(int'(inode_start), int'(data_begin), byte_at, bit_at)) begin
					number = byte_at * 8 + bit_at;
					if (number <= NUMBER_MAX) begin
						usage_map[byte_at][bit_at] = 1'b1;
						g.status = 1'b0;
						g.block_number = number[BLOCK_W-1:0];
					end
				end
			end
			CMD_DATA: begin
				if (find_free(int'(data_begin), int'(data_stop), byte_at, bit_at)) begin
					number = int'(data_base) + (byte_at - int'(data_begin)) * 8 + bit_at;
					if (number <= int'(block_limit)) begin
						usage_map[byte_at][bit_at] = 1'b1;
						g.status = 1'b0;
						g.block_number = number[BLOCK_W-1:0];
					end
				end
			end
			default: ;
		endcase
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		if (!arst_n) begin
			foreach (usage_map[i])
				usage_map[i] = '0;
			inode_start = INODE_FIRST_RESET;
			data_begin  = DATA_FIRST_RESET;
			data_stop   = DATA_END_RESET;
			data_base   = BASE_BLOCK_RESET;
			block_limit = LAST_BLOCK_RESET;
			grants_due.delete();
			pending <= 0;
		end else begin
			if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
				case (cfg.index)
					REG_INODE_FIRST_BYTE: inode_start = cfg.data[8:0];
					REG_DATA_FIRST_BYTE:  data_begin  = cfg.data[8:0];
					REG_DATA_END_BYTE:    data_stop   = cfg.data[9:0];
					REG_DATA_FIRST_BLOCK: data_base   = cfg.data[11:0];
					REG_LAST_BLOCK:       block_limit = cfg.data[11:0];
					default: ;
				endcase
			end
			if (cmd.valid === 1'b1 && cmd.ready === 1'b1)
				grants_due.push_back(apply_command(cmd.command, cmd.byte_index,
					cmd.byte_value));
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (grants_due.size() == 0) begin
					report_mismatch("response beat with no command outstanding");
				end else begin
					want = grants_due.pop_front();
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status %b, want %b",
							rsp.status, want.status));
					if (rsp.block_number !== want.block_number)
						report_mismatch($sformatf("block_number %0d, want %0d",
							rsp.block_number, want.block_number));
				end
			end
			pending <= grants_due.size();
		end
	end

endmodule

// File: test/bitmap_first_free_allocator_tb.sv
`timescale 1ns / 100ps
// Top of the allocator testbench: clock, reset, directed and random command beats,
// config phases and response back-pressure; the checker does all comparing.
// Depends on bfa_pkg, bfa_ifs, bitmap_first_free_allocator and its checker.
module bitmap_first_free_allocator_tb;
	import bfa_pkg::*;

	localparam logic [1:0] CMD_UNKNOWN  = 2'd3;
	localparam int         RANDOM_ITEMS = 1100;
	localparam int         HOLD_CYCLES  = 400;
	localparam int         HOLD_AT      = 300;
	localparam int         TAIL_CYCLES  = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   failures;
	int   pending;
	bit   quiet = 1'b0;
	bit   long_hold = 1'b0;
	int   cur_inode = 0;
	int   cur_data = 256;

	bfa_cmd_if cmd();
	bfa_rsp_if rsp();
	bfa_cfg_if cfg();

	bitmap_first_free_allocator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	bitmap_first_free_allocator_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rsp      (rsp),
		.cfg      (cfg),
		.failures (failures),
		.pending  (pending)
	);

	always #10 clk = ~clk;

	initial begin
		#(60_000_000);
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 96)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin : rsp_pacing
		int stall;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
				rsp.ready <= 1'b1;
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					rsp.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				rsp.ready <= 1'b1;
			end
		end
	end

	// leaves valid high; the next beat or drain decides what happens to it
	task automatic send_item(input logic [1:0] op, input logic [8:0] idx,
		input logic [7:0] val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid      <= 1'b1;
		cmd.command    <= op;
		cmd.byte_index <= idx;
		cmd.byte_value <= val;
		@(posedge clk);
		while (cmd.ready !== 1'b1) @(posedge clk);
	endtask

	task automatic drain();
		cmd.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input reg_index_t which, input int value);
		cfg.valid <= 1'b1;
		cfg.index <= which;
		cfg.data  <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		while (cfg.ready !== 1'b1) @(posedge clk);
	endtask

	task automatic set_config(input int first_inode, input int first_data, input int end_data,
		input int base_block, input int top_block);
		write_reg(REG_INODE_FIRST_BYTE, first_inode);
		write_reg(REG_DATA_FIRST_BYTE, first_data);
		write_reg(REG_DATA_END_BYTE, end_data);
		write_reg(REG_DATA_FIRST_BLOCK, base_block);
		write_reg(REG_LAST_BLOCK, top_block);
		cfg.valid <= 1'b0;
		cur_inode = first_inode & 511;
		cur_data = first_data & 511;
	endtask

	initial begin : stimulus
		int         sent;
		int         count;
		int         r;
		int         ifb;
		int         dfb;
		int         deb;
		int         dbase;
		int         lb;
		logic [1:0] op;
		logic [8:0] idx;
		logic [7:0] val;

		cmd.valid      <= 1'b0;
		cmd.command    <= CMD_LOAD;
		cmd.byte_index <= '0;
		cmd.byte_value <= '0;
		cfg.valid      <= 1'b0;
		cfg.index      <= REG_INODE_FIRST_BYTE;
		cfg.data       <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset config: inode bytes 0..255, data bytes 256..511
		send_item(CMD_LOAD, 9'd0, 8'hFF);
		send_item(CMD_LOAD, 9'd1, 8'h7F);
		send_item(CMD_INODE, 9'd0, 8'h00);
		send_item(CMD_INODE, 9'h1FF, 8'hFF);
		send_item(CMD_LOAD, 9'd511, 8'hAA);
		send_item(CMD_LOAD, 9'd256, 8'h55);
		send_item(CMD_DATA, 9'd0, 8'h00);
		send_item(CMD_UNKNOWN, 9'h1FF, 8'hFF);
		drain();

		// empty inode range, data numbers at the top of the block space
		set_config(511, 511, 512, 4095, 4095);
		send_item(CMD_INODE, 9'd0, 8'h00);
		send_item(CMD_DATA, 9'd0, 8'h00);
		send_item(CMD_DATA, 9'd0, 8'h00);
		drain();

		// reversed ranges
		set_config(300, 10, 0, 0, 0);
		send_item(CMD_INODE, 9'd0, 8'h00);
		send_item(CMD_DATA, 9'd0, 8'h00);
		drain();

		// data end past the bitmap
		set_config(0, 510, 1023, 100, 2047);
		send_item(CMD_LOAD, 9'd510, 8'hFF);
		send_item(CMD_LOAD, 9'd511, 8'hFF);
		send_item(CMD_DATA, 9'd0, 8'h00);
		send_item(CMD_LOAD, 9'd511, 8'h7F);
		send_item(CMD_DATA, 9'd0, 8'h00);
		drain();

		// data number past last_block leaves the bit clear
		set_config(0, 4, 6, 2, 3);
		send_item(CMD_DATA, 9'd0, 8'h00);
		send_item(CMD_DATA, 9'd0, 8'h00);
		send_item(CMD_DATA, 9'd0, 8'h00);
		send_item(CMD_INODE, 9'd0, 8'h00);
		drain();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 4))
				0: begin
					ifb = 0; dfb = 256; deb = 512; dbase = 0; lb = 2047;
				end
				1: begin
					ifb = $urandom_range(0, 511);
					dfb = ifb + $urandom_range(0, 6);
					if (dfb > 511)
						dfb = 511;
					deb = dfb + $urandom_range(0, 8);
					dbase = $urandom_range(0, 4095);
					lb = $urandom_range(0, 4095);
				end
				2: begin
					ifb = $urandom_range(0, 1) ? 511 : 0;
					dfb = $urandom_range(0, 1) ? 511 : 0;
					deb = $urandom_range(0, 1) ? 512 : 0;
					dbase = $urandom_range(0, 1) ? 4095 : 0;
					lb = $urandom_range(0, 1) ? 4095 : 0;
				end
				3: begin
					ifb = $urandom_range(0, 511);
					dfb = $urandom_range(0, 511);
					deb = $urandom_range(0, 512);
					dbase = $urandom_range(0, 4095);
					lb = $urandom_range(0, 4095);
				end
				default: begin
					ifb = $urandom_range(0, 500);
					dfb = ifb + $urandom_range(1, 10);
					deb = dfb + $urandom_range(1, 16);
					dbase = $urandom_range(0, 64);
					lb = 4095;
				end
			endcase
			set_config(ifb, dfb, deb, dbase, lb);
			quiet = ($urandom_range(0, 3) == 0);
			count = $urandom_range(60, 160);
			if (count > RANDOM_ITEMS - sent)
				count = RANDOM_ITEMS - sent;
			for (int n = 0; n < count; n++) begin
				r = $urandom_range(0, 99);
				if (r < 38)
					op = CMD_INODE;
				else if (r < 76)
					op = CMD_DATA;
				else if (r < 96)
					op = CMD_LOAD;
				else
					op = CMD_UNKNOWN;
				if ($urandom_range(0, 1))
					idx = 9'(($urandom_range(0, 1) ? cur_inode : cur_data)
						+ $urandom_range(0, 15));
				else
					idx = 9'($urandom_range(0, 511));
				case ($urandom_range(0, 3))
					0: val = 8'h00;
					1: val = 8'hFF;
					default: val = 8'($urandom_range(0, 255));
				endcase
				send_item(op, idx, val);
				sent++;
				if (sent == HOLD_AT)
					long_hold = 1'b1;
			end
			drain();
		end
		quiet = 1'b0;

		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
sv/bfa_pkg.sv
sv/bfa_ifs.sv
sv/bfa_ram.sv
sv/bitmap_first_free_allocator.sv
test/bitmap_first_free_allocator_checker.sv
test/bitmap_first_free_allocator_tb.sv
